// File: src/rde_pkg.sv
// shared types and constants for the decoded rv32i execute block
`default_nettype none
package rde_pkg;

  localparam int unsigned RegCountDef = 32;
  localparam logic [31:0] PcStep = 32'd4;
  localparam int unsigned UpperShift = 12;

  localparam logic [5:0] CmdAdd    = 6'd0;
  localparam logic [5:0] CmdSub    = 6'd1;
  localparam logic [5:0] CmdSlt    = 6'd2;
  localparam logic [5:0] CmdSltu   = 6'd3;
  localparam logic [5:0] CmdAnd    = 6'd4;
  localparam logic [5:0] CmdOr     = 6'd5;
  localparam logic [5:0] CmdXor    = 6'd6;
  localparam logic [5:0] CmdSll    = 6'd7;
  localparam logic [5:0] CmdSrl    = 6'd8;
  localparam logic [5:0] CmdSra    = 6'd9;
  localparam logic [5:0] CmdAddi   = 6'd10;
  localparam logic [5:0] CmdSlti   = 6'd11;
  localparam logic [5:0] CmdSltiu  = 6'd12;
  localparam logic [5:0] CmdAndi   = 6'd13;
  localparam logic [5:0] CmdOri    = 6'd14;
  localparam logic [5:0] CmdXori   = 6'd15;
  localparam logic [5:0] CmdSlli   = 6'd16;
  localparam logic [5:0] CmdSrli   = 6'd17;
  localparam logic [5:0] CmdSrai   = 6'd18;
  localparam logic [5:0] CmdBeq    = 6'd19;
  localparam logic [5:0] CmdBge    = 6'd20;
  localparam logic [5:0] CmdBgeu   = 6'd21;
  localparam logic [5:0] CmdBlt    = 6'd22;
  localparam logic [5:0] CmdBltu   = 6'd23;
  localparam logic [5:0] CmdBne    = 6'd24;
  localparam logic [5:0] CmdJal    = 6'd25;
  localparam logic [5:0] CmdJalr   = 6'd26;
  localparam logic [5:0] CmdAuipc  = 6'd27;
  localparam logic [5:0] CmdLui    = 6'd28;
  localparam logic [5:0] CmdLb     = 6'd29;
  localparam logic [5:0] CmdLbu    = 6'd30;
  localparam logic [5:0] CmdLh     = 6'd31;
  localparam logic [5:0] CmdLhu    = 6'd32;
  localparam logic [5:0] CmdLw     = 6'd33;
  localparam logic [5:0] CmdSb     = 6'd34;
  localparam logic [5:0] CmdSh     = 6'd35;
  localparam logic [5:0] CmdSw     = 6'd36;
  localparam logic [5:0] CmdHcf    = 6'd37;
  localparam logic [5:0] CmdUnimpl = 6'd38;
  localparam logic [5:0] CmdLret   = 6'd39;

  typedef enum logic [3:0] {
    ClsAlu, ClsAlui, ClsBranch, ClsJal, ClsJalr, ClsAuipc, ClsLui,
    ClsLoad, ClsStore, ClsHcf, ClsUnimpl, ClsLret
  } cls_e;

  typedef enum logic [3:0] {
    AluAdd, AluSub, AluSlt, AluSltu, AluAnd, AluOr, AluXor, AluSll, AluSrl, AluSra
  } alu_op_e;

  typedef enum logic [2:0] {
    BrEq, BrGe, BrGeu, BrLt, BrLtu, BrNe
  } br_e;

  typedef enum logic [1:0] {
    MemNone = 2'd0, MemRead = 2'd1, MemWrite = 2'd2
  } mem_req_e;

  typedef enum logic [1:0] {
    SizeByte = 2'd0, SizeHalf = 2'd1, SizeWord = 2'd2
  } mem_size_e;

  typedef enum logic [1:0] {
    StOk = 2'd0, StUnimpl = 2'd1, StHalt = 2'd2, StOrder = 2'd3
  } status_e;

  typedef struct packed {
    cls_e      cls;
    alu_op_e   alu_op;
    br_e       br;
    mem_size_e size;
    logic      uns;
    logic [4:0]  rd;
    logic [4:0]  ra_a;
    logic [4:0]  ra_b;
    logic        ok_a;
    logic        ok_b;
    logic [31:0] imm;
    logic [31:0] load_data;
  } op_t;

endpackage
`default_nettype wire

// File: src/rde_front.sv
// front end: takes items, classifies them and queues them for execution
`default_nettype none
module rde_front #(
  parameter int unsigned REGISTER_COUNT = rde_pkg::RegCountDef
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push,
  output      logic               full,
  input  wire logic [5:0]         command_i,
  input  wire logic [4:0]         first_reg_i,
  input  wire logic [4:0]         second_reg_i,
  input  wire logic [4:0]         third_reg_i,
  input  wire logic signed [31:0] immediate_i,
  input  wire logic [31:0]        load_data_i,
  output      logic               head_valid_o,
  output      rde_pkg::op_t       head_o,
  input  wire logic               deq_i
);
  import rde_pkg::*;

  localparam logic [5:0] RegLimit = 6'(REGISTER_COUNT);

  op_t        dec;
  op_t        q_mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       enq, deq;

  always_comb begin
    dec           = '0;
    dec.cls       = ClsUnimpl;
    dec.alu_op    = AluAdd;
    dec.br        = BrEq;
    dec.size      = SizeByte;
    dec.uns       = 1'b0;
    dec.rd        = first_reg_i;
    dec.ra_a      = second_reg_i;
    dec.ra_b      = first_reg_i;
    dec.imm       = 32'(unsigned'(immediate_i));
    dec.load_data = load_data_i;
    case (command_i)
      CmdAdd:    begin dec.cls = ClsAlu;  dec.alu_op = AluAdd;  end
      CmdSub:    begin dec.cls = ClsAlu;  dec.alu_op = AluSub;  end
      CmdSlt:    begin dec.cls = ClsAlu;  dec.alu_op = AluSlt;  end
      CmdSltu:   begin dec.cls = ClsAlu;  dec.alu_op = AluSltu; end
      CmdAnd:    begin dec.cls = ClsAlu;  dec.alu_op = AluAnd;  end
      CmdOr:     begin dec.cls = ClsAlu;  dec.alu_op = AluOr;   end
      CmdXor:    begin dec.cls = ClsAlu;  dec.alu_op = AluXor;  end
      CmdSll:    begin dec.cls = ClsAlu;  dec.alu_op = AluSll;  end
      CmdSrl:    begin dec.cls = ClsAlu;  dec.alu_op = AluSrl;  end
      CmdSra:    begin dec.cls = ClsAlu;  dec.alu_op = AluSra;  end
      CmdAddi:   begin dec.cls = ClsAlui; dec.alu_op = AluAdd;  end
      CmdSlti:   begin dec.cls = ClsAlui; dec.alu_op = AluSlt;  end
      CmdSltiu:  begin dec.cls = ClsAlui; dec.alu_op = AluSltu; end
      CmdAndi:   begin dec.cls = ClsAlui; dec.alu_op = AluAnd;  end
      CmdOri:    begin dec.cls = ClsAlui; dec.alu_op = AluOr;   end
      CmdXori:   begin dec.cls = ClsAlui; dec.alu_op = AluXor;  end
      CmdSlli:   begin dec.cls = ClsAlui; dec.alu_op = AluSll;  end
      CmdSrli:   begin dec.cls = ClsAlui; dec.alu_op = AluSrl;  end
      CmdSrai:   begin dec.cls = ClsAlui; dec.alu_op = AluSra;  end
      CmdBeq:    begin dec.cls = ClsBranch; dec.br = BrEq;  end
      CmdBge:    begin dec.cls = ClsBranch; dec.br = BrGe;  end
      CmdBgeu:   begin dec.cls = ClsBranch; dec.br = BrGeu; end
      CmdBlt:    begin dec.cls = ClsBranch; dec.br = BrLt;  end
      CmdBltu:   begin dec.cls = ClsBranch; dec.br = BrLtu; end
      CmdBne:    begin dec.cls = ClsBranch; dec.br = BrNe;  end
      CmdJal:    dec.cls = ClsJal;
      CmdJalr:   dec.cls = ClsJalr;
      CmdAuipc:  dec.cls = ClsAuipc;
      CmdLui:    dec.cls = ClsLui;
      CmdLb:     begin dec.cls = ClsLoad; dec.size = SizeByte; end
      CmdLbu:    begin dec.cls = ClsLoad; dec.size = SizeByte; dec.uns = 1'b1; end
      CmdLh:     begin dec.cls = ClsLoad; dec.size = SizeHalf; end
      CmdLhu:    begin dec.cls = ClsLoad; dec.size = SizeHalf; dec.uns = 1'b1; end
      CmdLw:     begin dec.cls = ClsLoad; dec.size = SizeWord; end
      CmdSb:     begin dec.cls = ClsStore; dec.size = SizeByte; end
      CmdSh:     begin dec.cls = ClsStore; dec.size = SizeHalf; end
      CmdSw:     begin dec.cls = ClsStore; dec.size = SizeWord; end
      CmdHcf:    dec.cls = ClsHcf;
      CmdLret:   dec.cls = ClsLret;
      default:   dec.cls = ClsUnimpl;
    endcase
    if (dec.cls == ClsAlu) begin
      dec.ra_b = third_reg_i;
    end
    dec.ok_a = (dec.ra_a != 5'd0) && ({1'b0, dec.ra_a} < RegLimit);
    dec.ok_b = (dec.ra_b != 5'd0) && ({1'b0, dec.ra_b} < RegLimit);
  end

  assign full         = (cnt_q == 2'd2);
  assign head_valid_o = (cnt_q != 2'd0);
  assign head_o       = q_mem_q[rd_ptr_q];
  assign enq          = push && !full;
  assign deq          = deq_i && head_valid_o;

  always_ff @(posedge clk_i) begin
    if (enq) begin
      q_mem_q[wr_ptr_q] <= dec;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (enq) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (deq) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      if (enq && !deq) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (deq && !enq) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

endmodule
`default_nettype wire

// File: src/rde_back.sv
// back end: register file read, execute, architectural state and result queue
`default_nettype none
module rde_back #(
  parameter int unsigned REGISTER_COUNT = rde_pkg::RegCountDef
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         head_valid_i,
  input  wire rde_pkg::op_t head_i,
  output      logic         deq_o,
  input  wire logic         cfg_valid_i,
  output      logic         cfg_ready_o,
  input  wire logic [31:0]  cfg_data_i,
  output      logic         empty,
  input  wire logic         pop,
  output      logic [31:0]  instr_pc_o,
  output      logic [31:0]  next_pc_o,
  output      logic         branch_taken_o,
  output      logic [1:0]   mem_request_o,
  output      logic [31:0]  mem_address_o,
  output      logic [1:0]   mem_size_o,
  output      logic         mem_unsigned_o,
  output      logic [31:0]  store_data_o,
  output      logic [4:0]   written_reg_o,
  output      logic [31:0]  written_value_o,
  output      logic [1:0]   status_o
);
  import rde_pkg::*;

  localparam int unsigned   IdxW     = $clog2(REGISTER_COUNT);
  localparam logic [5:0]    RegLimit = 6'(REGISTER_COUNT);

  typedef struct packed {
    logic [31:0] instr_pc;
    logic [31:0] next_pc;
    logic        taken;
    mem_req_e    req;
    logic [31:0] addr;
    mem_size_e   size;
    logic        uns;
    logic [31:0] sdata;
    logic [4:0]  wreg;
    logic [31:0] wval;
    status_e     status;
  } res_t;

  function automatic logic [31:0] alu_f(alu_op_e op, logic [31:0] a, logic [31:0] b);
    logic [4:0]  sh;
    logic [31:0] r;
    sh = b[4:0];
    case (op)
      AluAdd:  r = a + b;
      AluSub:  r = a - b;
      AluSlt:  r = {31'd0, $signed(a) < $signed(b)};
      AluSltu: r = {31'd0, a < b};
      AluAnd:  r = a & b;
      AluOr:   r = a | b;
      AluXor:  r = a ^ b;
      AluSll:  r = a << sh;
      AluSrl:  r = a >> sh;
      AluSra:  r = 32'($signed(a) >>> sh);
      default: r = 32'd0;
    endcase
    return r;
  endfunction

  logic [31:0] rf_q [REGISTER_COUNT];
  logic [REGISTER_COUNT-1:0] rf_vld_q;

  logic        rs_vld_q;
  op_t         rs_op_q;
  logic [31:0] opa_q, opb_q;
  logic        opa_v_q, opb_v_q;

  logic [31:0] pc_q;
  logic        halted_q, lpend_q;
  logic [4:0]  ldst_q;

  res_t       of_mem_q [2];
  logic       of_wr_q, of_rd_q;
  logic [1:0] of_cnt_q;
  logic       of_full, of_pop;

  logic        exe_fire, rs_load;
  logic        byp_a, byp_b, hold_a, hold_b;
  logic [31:0] src_a, src_b, alu_b, alu_res, pc4, sum_ab;
  logic        take;
  res_t        res;
  logic [31:0] npc;
  logic        wr_want;
  logic [4:0]  wr_idx;
  logic [31:0] wr_data;
  logic        rf_we;
  logic        halted_d, lpend_d;
  logic [4:0]  ldst_d;

  assign of_full  = (of_cnt_q == 2'd2);
  assign exe_fire = rs_vld_q && !of_full;
  assign rs_load  = head_valid_i && (!rs_vld_q || exe_fire);
  assign deq_o    = rs_load;
  assign cfg_ready_o = 1'b1;

  assign src_a  = opa_v_q ? opa_q : 32'd0;
  assign src_b  = opb_v_q ? opb_q : 32'd0;
  assign alu_b  = (rs_op_q.cls == ClsAlu) ? src_b : rs_op_q.imm;
  assign alu_res = alu_f(rs_op_q.alu_op, src_a, alu_b);
  assign pc4    = pc_q + PcStep;
  assign sum_ab = src_a + rs_op_q.imm;

  always_comb begin
    case (rs_op_q.br)
      BrEq:    take = (src_b == src_a);
      BrGe:    take = !($signed(src_b) < $signed(src_a));
      BrGeu:   take = (src_b >= src_a);
      BrLt:    take = ($signed(src_b) < $signed(src_a));
      BrLtu:   take = (src_b < src_a);
      BrNe:    take = (src_b != src_a);
      default: take = 1'b0;
    endcase
  end

  always_comb begin
    res          = '0;
    res.instr_pc = pc_q;
    res.req      = MemNone;
    res.size     = SizeByte;
    res.status   = StOk;
    npc          = pc4;
    wr_want      = 1'b0;
    wr_idx       = rs_op_q.rd;
    wr_data      = 32'd0;
    halted_d     = halted_q;
    lpend_d      = lpend_q;
    ldst_d       = ldst_q;
    if (halted_q) begin
      npc        = pc_q;
      res.status = StHalt;
    end else if (lpend_q != (rs_op_q.cls == ClsLret)) begin
      npc        = pc_q;
      res.status = StOrder;
    end else begin
      case (rs_op_q.cls)
        ClsLret: begin
          npc     = pc_q;
          wr_want = 1'b1;
          wr_idx  = ldst_q;
          wr_data = rs_op_q.load_data;
          lpend_d = 1'b0;
        end
        ClsAlu, ClsAlui: begin
          wr_want = 1'b1;
          wr_data = alu_res;
        end
        ClsBranch: begin
          if (take) begin
            npc = rs_op_q.imm;
          end
        end
        ClsJal: begin
          wr_want = 1'b1;
          wr_data = pc4;
          npc     = rs_op_q.imm;
        end
        ClsJalr: begin
          wr_want = 1'b1;
          wr_data = pc4;
          npc     = {sum_ab[31:1], 1'b0};
        end
        ClsAuipc: begin
          wr_want = 1'b1;
          wr_data = pc_q + (rs_op_q.imm << UpperShift);
        end
        ClsLui: begin
          wr_want = 1'b1;
          wr_data = rs_op_q.imm << UpperShift;
        end
        ClsLoad: begin
          res.req  = MemRead;
          res.addr = sum_ab;
          res.size = rs_op_q.size;
          res.uns  = rs_op_q.uns;
          lpend_d  = 1'b1;
          ldst_d   = rs_op_q.rd;
        end
        ClsStore: begin
          res.req   = MemWrite;
          res.addr  = sum_ab;
          res.size  = rs_op_q.size;
          res.sdata = src_b;
        end
        ClsHcf: begin
          halted_d   = 1'b1;
          res.status = StHalt;
        end
        default: res.status = StUnimpl;
      endcase
    end
    if (wr_want && (wr_idx != 5'd0) && ({1'b0, wr_idx} < RegLimit)) begin
      res.wreg = wr_idx;
      res.wval = wr_data;
    end
    res.next_pc = npc;
    // a halt command seen while already halted reports its held pc as a jump
    res.taken   = (((res.status == StOk) && (rs_op_q.cls != ClsLret)) ||
                   ((res.status == StHalt) && (rs_op_q.cls == ClsHcf))) && (npc != pc4);
  end

  assign rf_we  = exe_fire && (res.wreg != 5'd0);
  assign byp_a  = rf_we && (res.wreg == head_i.ra_a);
  assign byp_b  = rf_we && (res.wreg == head_i.ra_b);
  assign hold_a = rf_we && (res.wreg == rs_op_q.ra_a);
  assign hold_b = rf_we && (res.wreg == rs_op_q.ra_b);

  always_ff @(posedge clk_i) begin
    if (rf_we) begin
      rf_q[res.wreg[IdxW-1:0]] <= res.wval;
    end
    if (rs_load) begin
      rs_op_q <= head_i;
      opa_q   <= byp_a ? res.wval : rf_q[head_i.ra_a[IdxW-1:0]];
      opb_q   <= byp_b ? res.wval : rf_q[head_i.ra_b[IdxW-1:0]];
    end else begin
      if (hold_a) begin
        opa_q <= res.wval;
      end
      if (hold_b) begin
        opb_q <= res.wval;
      end
    end
    if (exe_fire) begin
      of_mem_q[of_wr_q] <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rf_vld_q <= '0;
      rs_vld_q <= 1'b0;
      opa_v_q  <= 1'b0;
      opb_v_q  <= 1'b0;
      pc_q     <= 32'd0;
      halted_q <= 1'b0;
      lpend_q  <= 1'b0;
      ldst_q   <= 5'd0;
      of_wr_q  <= 1'b0;
      of_rd_q  <= 1'b0;
      of_cnt_q <= 2'd0;
    end else begin
      if (rf_we) begin
        rf_vld_q[res.wreg[IdxW-1:0]] <= 1'b1;
      end
      if (rs_load) begin
        rs_vld_q <= 1'b1;
        opa_v_q  <= head_i.ok_a && (byp_a || rf_vld_q[head_i.ra_a[IdxW-1:0]]);
        opb_v_q  <= head_i.ok_b && (byp_b || rf_vld_q[head_i.ra_b[IdxW-1:0]]);
      end else begin
        if (exe_fire) begin
          rs_vld_q <= 1'b0;
        end
        if (hold_a) begin
          opa_v_q <= rs_op_q.ok_a;
        end
        if (hold_b) begin
          opb_v_q <= rs_op_q.ok_b;
        end
      end
      if (cfg_valid_i) begin
        pc_q <= cfg_data_i;
      end else if (exe_fire) begin
        pc_q <= npc;
      end
      if (exe_fire) begin
        halted_q <= halted_d;
        lpend_q  <= lpend_d;
        ldst_q   <= ldst_d;
        of_wr_q  <= !of_wr_q;
      end
      if (of_pop) begin
        of_rd_q <= !of_rd_q;
      end
      if (exe_fire && !of_pop) begin
        of_cnt_q <= of_cnt_q + 2'd1;
      end else if (of_pop && !exe_fire) begin
        of_cnt_q <= of_cnt_q - 2'd1;
      end
    end
  end

  // result queue head
  assign empty  = (of_cnt_q == 2'd0);
  assign of_pop = pop && !empty;

  assign instr_pc_o      = of_mem_q[of_rd_q].instr_pc;
  assign next_pc_o       = of_mem_q[of_rd_q].next_pc;
  assign branch_taken_o  = of_mem_q[of_rd_q].taken;
  assign mem_request_o   = of_mem_q[of_rd_q].req;
  assign mem_address_o   = of_mem_q[of_rd_q].addr;
  assign mem_size_o      = of_mem_q[of_rd_q].size;
  assign mem_unsigned_o  = of_mem_q[of_rd_q].uns;
  assign store_data_o    = of_mem_q[of_rd_q].sdata;
  assign written_reg_o   = of_mem_q[of_rd_q].wreg;
  assign written_value_o = of_mem_q[of_rd_q].wval;
  assign status_o        = of_mem_q[of_rd_q].status;

  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halted_q && exe_fire |-> res.status == StHalt && npc == pc_q)
    else $error("item executed after halt");

  a_load_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    exe_fire && lpend_q && rs_op_q.cls != ClsLret && !halted_q |-> res.status == StOrder)
    else $error("load return skipped");

  a_no_x0_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rf_we |-> res.wreg != 5'd0 && {1'b0, res.wreg} < RegLimit)
    else $error("write to register zero or beyond file");

  a_pc_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    exe_fire && !cfg_valid_i |=> pc_q == $past(npc))
    else $error("pc not updated from executed item");

endmodule
`default_nettype wire

// File: src/rv32i_decoded_execute.sv
// top level of the decoded rv32i execute block
// Executes one pre-decoded RV32I item per cycle when neither side stalls. An item
// passes a two-entry input queue, a register read stage and the execute stage, which
// writes the result into a two-entry result queue that drives the outputs; the single
// execute stage, which owns the pc and the register file write port, sets the rate of
// one item per cycle. Loads return a read request and must be followed by a load return
// item carrying the data. Write the start address only while the block is idle; it loads
// the pc at once.
`default_nettype none
module rv32i_decoded_execute #(
  parameter int unsigned REGISTER_COUNT = rde_pkg::RegCountDef
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push,
  output      logic               full,
  input  wire logic [5:0]         command_i,
  input  wire logic [4:0]         first_reg_i,
  input  wire logic [4:0]         second_reg_i,
  input  wire logic [4:0]         third_reg_i,
  input  wire logic signed [31:0] immediate_i,
  input  wire logic [31:0]        load_data_i,
  output      logic               empty,
  input  wire logic               pop,
  output      logic [31:0]        instr_pc_o,
  output      logic [31:0]        next_pc_o,
  output      logic               branch_taken_o,
  output      logic [1:0]         mem_request_o,
  output      logic [31:0]        mem_address_o,
  output      logic [1:0]         mem_size_o,
  output      logic               mem_unsigned_o,
  output      logic [31:0]        store_data_o,
  output      logic [4:0]         written_reg_o,
  output      logic [31:0]        written_value_o,
  output      logic [1:0]         status_o,
  input  wire logic               cfg_valid_i,
  output      logic               cfg_ready_o,
  input  wire logic [31:0]        cfg_data_i
);
  import rde_pkg::*;

  op_t  head;
  logic head_valid, deq;

  rde_front #(
    .REGISTER_COUNT(REGISTER_COUNT)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .command_i    (command_i),
    .first_reg_i  (first_reg_i),
    .second_reg_i (second_reg_i),
    .third_reg_i  (third_reg_i),
    .immediate_i  (immediate_i),
    .load_data_i  (load_data_i),
    .head_valid_o (head_valid),
    .head_o       (head),
    .deq_i        (deq)
  );

  rde_back #(
    .REGISTER_COUNT(REGISTER_COUNT)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .head_valid_i    (head_valid),
    .head_i          (head),
    .deq_o           (deq),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i),
    .empty           (empty),
    .pop             (pop),
    .instr_pc_o      (instr_pc_o),
    .next_pc_o       (next_pc_o),
    .branch_taken_o  (branch_taken_o),
    .mem_request_o   (mem_request_o),
    .mem_address_o   (mem_address_o),
    .mem_size_o      (mem_size_o),
    .mem_unsigned_o  (mem_unsigned_o),
    .store_data_o    (store_data_o),
    .written_reg_o   (written_reg_o),
    .written_value_o (written_value_o),
    .status_o        (status_o)
  );

endmodule
`default_nettype wire
